// ===== design/gtq_pkg.sv =====
// ----------------------------------------------------------------------------
// gtq_pkg
// Shared types, constants and helper functions for the group tier qualifier.
// ----------------------------------------------------------------------------
package gtq_pkg;

	// Default widths, handed to the top level as parameter defaults
	localparam int COUNT_BITS_DEF = 16;
	localparam int STAT_BITS_DEF  = 32;

	// Fixed field widths
	localparam int Q_BITS    = 17;
	localparam int STAB_BITS = 8;
	localparam int TIER_BITS = 3;
	localparam int CAP_BITS  = 10;

	// Q1.16 unity
	localparam logic [Q_BITS-1:0] Q_ONE = 17'h10000;

	// Register reset values
	localparam logic [Q_BITS-1:0]    COH_THR_RST = 17'd45875;
	localparam logic [STAB_BITS-1:0] STAB_RST    = 8'd3;
	localparam logic [Q_BITS-1:0]    RATIO_RST   = 17'd32768;

	localparam logic [TIER_BITS-1:0] TIER_MAX = 3'd5;

	// Lower bound of tiers 1..5
	localparam int NUM_TIER_BOUNDS = 5;
	localparam logic [5:0] TIER_FLOOR [NUM_TIER_BOUNDS] = '{6'd2, 6'd4, 6'd8, 6'd16, 6'd32};

	// Register indexes (paddr[3:2])
	typedef enum logic [1:0] {
		REG_COH_THR = 2'd0,
		REG_STAB    = 2'd1,
		REG_RATIO   = 2'd2
	} reg_idx_t;

	// Outcome of the front-end checks
	typedef enum logic [1:0] {
		KIND_INVALID     = 2'd0,
		KIND_HEALTH_FAIL = 2'd1,
		KIND_COHER_FAIL  = 2'd2,
		KIND_QUALIFY     = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t                 kind;
		logic [TIER_BITS-1:0]  tier;
	} class_t;

	// Configuration as seen by the front and back ends
	typedef struct packed {
		logic [Q_BITS-1:0]    coh_thr;
		logic [STAB_BITS-1:0] stab;
		logic [Q_BITS-1:0]    ratio;
	} cfg_t;

	// Raw tier of a connected count
	function automatic logic [TIER_BITS-1:0] tier_of(input logic [31:0] count);
		logic [TIER_BITS-1:0] t;
		t = '0;
		for (int i = 0; i < NUM_TIER_BOUNDS; i++) begin
			if (count >= {26'd0, TIER_FLOOR[i]}) begin
				t = TIER_BITS'(i + 1);
			end
		end
		return t;
	endfunction

	// Cumulative capability mask, two bits per tier step
	function automatic logic [CAP_BITS-1:0] cap_mask(input logic [TIER_BITS-1:0] t);
		logic [CAP_BITS-1:0] m;
		case (t)
			3'd0: m = 10'h000;
			3'd1: m = 10'h003;
			3'd2: m = 10'h00F;
			3'd3: m = 10'h03F;
			3'd4: m = 10'h0FF;
			default: m = 10'h3FF;
		endcase
		return m;
	endfunction

endpackage

// ===== design/group_tier_qualifier.sv =====
// ----------------------------------------------------------------------------
// group_tier_qualifier
// Qualifies group health and coherence reports and tracks an adopted tier.
// ----------------------------------------------------------------------------
// The block takes one report per clock while the queue has room, and
// returns one status item per report: the front end classifies a report
// in the accept cycle and writes it into a two-entry queue, the back end
// applies it to the tier state and statistics and registers the result.
// Sustained throughput is one report per clock while the output is not
// stalled. The output carries tuser = 1 for a rejected report, in which
// case every field shows the unchanged state. Configuration registers
// (coherence threshold at 0x0, stability count at 0x4, minimum health
// ratio at 0x8) are written through the APB port and should only change
// while no report is in flight.
module group_tier_qualifier #(
	parameter int COUNT_BITS = gtq_pkg::COUNT_BITS_DEF,
	parameter int STAT_BITS  = gtq_pkg::STAT_BITS_DEF,
	localparam int IN_RAW    = 2 * COUNT_BITS + gtq_pkg::Q_BITS,
	localparam int IN_BITS   = ((IN_RAW + 7) / 8) * 8,
	localparam int OUT_RAW   = 17 + 5 * STAT_BITS + 2 * COUNT_BITS,
	localparam int OUT_BITS  = ((OUT_RAW + 7) / 8) * 8
) (
	input  logic                clk,
	input  logic                arst_n,
	// APB configuration
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	// Reports in
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [IN_BITS-1:0]  s_tdata,   // connected_count, healthy_count, coherence_level
	// Status out
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [OUT_BITS-1:0] m_tdata,   // tier, capability_mask, tier_pending,
	                                       // update_count, health_fail_count,
	                                       // coherence_fail_count, tier_change_count,
	                                       // violation_count, highest_tier,
	                                       // max_count_seen, min_count_seen
	output logic                m_tuser    // status
);

	localparam int QW       = $bits(gtq_pkg::class_t) + COUNT_BITS;
	localparam int HIGH_LSB = 14 + 5 * STAT_BITS;

	gtq_pkg::cfg_t          cfg_q;
	gtq_pkg::reg_idx_t      reg_idx;
	gtq_pkg::class_t        front_cls;
	gtq_pkg::class_t        back_cls;
	logic                   wr_en;
	logic                   q_full;
	logic                   q_empty;
	logic                   q_pop;
	logic [QW-1:0]          q_out;
	logic [COUNT_BITS-1:0]  back_conn;

	// Configuration registers
	assign pready  = 1'b1;
	assign reg_idx = gtq_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.coh_thr <= gtq_pkg::COH_THR_RST;
			cfg_q.stab    <= gtq_pkg::STAB_RST;
			cfg_q.ratio   <= gtq_pkg::RATIO_RST;
		end else if (wr_en) begin
			case (reg_idx)
				gtq_pkg::REG_COH_THR: cfg_q.coh_thr <= pwdata[gtq_pkg::Q_BITS-1:0];
				gtq_pkg::REG_STAB:    cfg_q.stab    <= pwdata[gtq_pkg::STAB_BITS-1:0];
				gtq_pkg::REG_RATIO:   cfg_q.ratio   <= pwdata[gtq_pkg::Q_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Register readback
	always_comb begin
		case (reg_idx)
			gtq_pkg::REG_COH_THR: prdata = 32'(cfg_q.coh_thr);
			gtq_pkg::REG_STAB:    prdata = 32'(cfg_q.stab);
			gtq_pkg::REG_RATIO:   prdata = 32'(cfg_q.ratio);
			default:              prdata = '0;
		endcase
	end

	// Front end: classify on acceptance
	assign s_tready = !q_full;

	gtq_front #(
		.COUNT_BITS(COUNT_BITS)
	) u_front (
		.cfg             (cfg_q),
		.connected_count (s_tdata[COUNT_BITS-1:0]),
		.healthy_count   (s_tdata[2*COUNT_BITS-1:COUNT_BITS]),
		.coherence_level (s_tdata[IN_RAW-1:2*COUNT_BITS]),
		.cls             (front_cls)
	);

	gtq_queue #(
		.WIDTH(QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (s_tvalid && s_tready),
		.push_data ({front_cls, s_tdata[COUNT_BITS-1:0]}),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_out),
		.empty     (q_empty)
	);

	assign back_cls  = gtq_pkg::class_t'(q_out[QW-1:COUNT_BITS]);
	assign back_conn = q_out[COUNT_BITS-1:0];

	// Back end: state update and output register
	gtq_back #(
		.COUNT_BITS (COUNT_BITS),
		.STAT_BITS  (STAT_BITS),
		.OUT_BITS   (OUT_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.stab     (cfg_q.stab),
		.q_empty  (q_empty),
		.q_cls    (back_cls),
		.q_conn   (back_conn),
		.pop      (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// Adopted tier stays within range
	a_tier_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[2:0] <= gtq_pkg::TIER_MAX))
		else $error("adopted tier out of range");

	// Capability mask follows the adopted tier
	a_cap_mask: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[12:3] == gtq_pkg::cap_mask(m_tdata[2:0])))
		else $error("capability mask does not match tier");

	// Highest tier never below the adopted tier
	a_peak_tier: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[HIGH_LSB +: 3] >= m_tdata[2:0]))
		else $error("highest tier below adopted tier");

endmodule

// ===== design/gtq_front.sv =====
// ----------------------------------------------------------------------------
// gtq_front
// Classifies an incoming update: invalid, health failure, coherence failure
// or qualifying with its raw tier.
// ----------------------------------------------------------------------------
module gtq_front #(
	parameter int COUNT_BITS = gtq_pkg::COUNT_BITS_DEF
) (
	input  gtq_pkg::cfg_t                  cfg,
	input  logic [COUNT_BITS-1:0]          connected_count,
	input  logic [COUNT_BITS-1:0]          healthy_count,
	input  logic [gtq_pkg::Q_BITS-1:0]     coherence_level,
	output gtq_pkg::class_t                cls
);

	localparam int PROD_BITS = COUNT_BITS + gtq_pkg::Q_BITS;

	logic [PROD_BITS-1:0] ratio_prod;
	logic [PROD_BITS-1:0] healthy_scaled;
	logic                 invalid;
	logic                 health_fail;

	// healthy * 2^16 against ratio * connected, exact
	assign ratio_prod     = PROD_BITS'(cfg.ratio) * PROD_BITS'(connected_count);
	assign healthy_scaled = PROD_BITS'({healthy_count, 16'd0});

	assign invalid     = (healthy_count > connected_count) ||
	                     (coherence_level > gtq_pkg::Q_ONE);
	assign health_fail = (connected_count == '0) || (healthy_scaled < ratio_prod);

	// Priority: invalid, health, coherence, then tier mapping
	always_comb begin
		cls.tier = gtq_pkg::tier_of(32'(connected_count));
		if (invalid) begin
			cls.kind = gtq_pkg::KIND_INVALID;
		end else if (health_fail) begin
			cls.kind = gtq_pkg::KIND_HEALTH_FAIL;
		end else if (coherence_level < cfg.coh_thr) begin
			cls.kind = gtq_pkg::KIND_COHER_FAIL;
		end else begin
			cls.kind = gtq_pkg::KIND_QUALIFY;
		end
	end

endmodule

// ===== design/gtq_queue.sv =====
// ----------------------------------------------------------------------------
// gtq_queue
// Two-entry queue between the classifying front end and the state back end.
// ----------------------------------------------------------------------------
module gtq_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);

	logic [WIDTH-1:0] entry_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	assign full     = (count_q == 2'd2);
	assign empty    = (count_q == 2'd0);
	assign pop_data = entry_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== design/gtq_back.sv =====
// ----------------------------------------------------------------------------
// gtq_back
// Tier qualification state, statistics and the registered status output.
// ----------------------------------------------------------------------------
module gtq_back #(
	parameter int COUNT_BITS = gtq_pkg::COUNT_BITS_DEF,
	parameter int STAT_BITS  = gtq_pkg::STAT_BITS_DEF,
	parameter int OUT_BITS   = 216
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [gtq_pkg::STAB_BITS-1:0]     stab,
	input  logic                              q_empty,
	input  gtq_pkg::class_t                   q_cls,
	input  logic [COUNT_BITS-1:0]             q_conn,
	output logic                              pop,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [OUT_BITS-1:0]               m_tdata,
	output logic                              m_tuser
);

	localparam int TB = gtq_pkg::TIER_BITS;

	// Current state
	logic [TB-1:0]                 adopted_q, cand_q, peak_q;
	logic                          flag_q;
	logic [gtq_pkg::STAB_BITS-1:0] rep_q;
	logic [gtq_pkg::CAP_BITS-1:0]  cap_q;
	logic [STAT_BITS-1:0]          upd_q, hfail_q, cfail_q, chg_q, viol_q;
	logic [COUNT_BITS-1:0]         max_q, min_q;

	// Next state
	logic [TB-1:0]                 adopted_n, cand_n, peak_n;
	logic                          flag_n;
	logic [gtq_pkg::STAB_BITS-1:0] rep_n, rep_inc;
	logic [gtq_pkg::CAP_BITS-1:0]  cap_n;
	logic [STAT_BITS-1:0]          upd_n, hfail_n, cfail_n, chg_n, viol_n;
	logic [COUNT_BITS-1:0]         max_n, min_n;

	logic                          out_valid_q;
	logic [OUT_BITS-1:0]           out_data_q;
	logic                          out_status_q;

	// Take a request when the output register is free or being drained
	assign pop      = !q_empty && (!out_valid_q || m_tready);
	assign rep_inc  = rep_q + 8'd1;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_status_q;

	// Statistics and qualification for one request
	always_comb begin
		adopted_n = adopted_q;
		cand_n    = cand_q;
		peak_n    = peak_q;
		flag_n    = flag_q;
		rep_n     = rep_q;
		cap_n     = cap_q;
		upd_n     = upd_q;
		hfail_n   = hfail_q;
		cfail_n   = cfail_q;
		chg_n     = chg_q;
		viol_n    = viol_q;
		max_n     = max_q;
		min_n     = min_q;
		if (q_cls.kind != gtq_pkg::KIND_INVALID) begin
			upd_n = upd_q + STAT_BITS'(1);
			if (q_conn > max_q) begin
				max_n = q_conn;
			end
			if (q_conn < min_q) begin
				min_n = q_conn;
			end
		end
		case (q_cls.kind)
			gtq_pkg::KIND_HEALTH_FAIL: hfail_n = hfail_q + STAT_BITS'(1);
			gtq_pkg::KIND_COHER_FAIL:  cfail_n = cfail_q + STAT_BITS'(1);
			gtq_pkg::KIND_QUALIFY: begin
				if (q_cls.tier == adopted_q) begin
					rep_n  = '0;
					flag_n = 1'b0;
				end else if (!flag_q || (q_cls.tier != cand_q)) begin
					// new pending transition
					cand_n = q_cls.tier;
					rep_n  = 8'd1;
					flag_n = 1'b1;
					viol_n = viol_q + STAT_BITS'(1);
				end else if (rep_inc >= stab) begin
					// candidate stable long enough: adopt
					rep_n     = '0;
					flag_n    = 1'b0;
					adopted_n = q_cls.tier;
					chg_n     = chg_q + STAT_BITS'(1);
					cap_n     = gtq_pkg::cap_mask(q_cls.tier);
					if (q_cls.tier > peak_q) begin
						peak_n = q_cls.tier;
					end
				end else begin
					rep_n = rep_inc;
				end
			end
			default: ;
		endcase
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adopted_q <= '0;
			cand_q    <= '0;
			peak_q    <= '0;
			flag_q    <= 1'b0;
			rep_q     <= '0;
			cap_q     <= '0;
			upd_q     <= '0;
			hfail_q   <= '0;
			cfail_q   <= '0;
			chg_q     <= '0;
			viol_q    <= '0;
			max_q     <= '0;
			min_q     <= '1;
		end else if (pop) begin
			adopted_q <= adopted_n;
			cand_q    <= cand_n;
			peak_q    <= peak_n;
			flag_q    <= flag_n;
			rep_q     <= rep_n;
			cap_q     <= cap_n;
			upd_q     <= upd_n;
			hfail_q   <= hfail_n;
			cfail_q   <= cfail_n;
			chg_q     <= chg_n;
			viol_q    <= viol_n;
			max_q     <= max_n;
			min_q     <= min_n;
		end
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload: post-update state, packed from the lowest bit up
	always_ff @(posedge clk) begin
		if (pop) begin
			out_status_q <= (q_cls.kind == gtq_pkg::KIND_INVALID);
			out_data_q   <= OUT_BITS'({min_n, max_n, peak_n, viol_n, chg_n, cfail_n,
			                           hfail_n, upd_n, flag_n, cap_n, adopted_n});
		end
	end

endmodule

// ===== test/group_tier_qualifier_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// group_tier_qualifier_tb
// Self-checking bench for the group tier qualifier. Reports go in on the
// stream slave port in random bursts, and status words come back while the
// output stalls on a pattern of its own. A bench-side model of the tier state
// and statistics predicts every status word, and each field is compared. The
// configuration registers are written over APB while the block is idle and
// read back. Register values cover the defaults, the extremes and
// out-of-range values.
// ----------------------------------------------------------------------------
module group_tier_qualifier_tb;

	localparam int IN_BITS   = 56;
	localparam int OUT_BITS  = 216;
	localparam int MAX_CYC   = 600000;
	localparam int TAIL_CYC  = 6;
	localparam int MAX_PRINT = 100;

	localparam int Q_W    = gtq_pkg::Q_BITS;
	localparam int TIER_W = gtq_pkg::TIER_BITS;
	localparam int CAP_W  = gtq_pkg::CAP_BITS;
	localparam int STAB_W = gtq_pkg::STAB_BITS;

	// One report, connected count in the lowest bits
	typedef struct packed {
		logic [Q_W-1:0] coh;
		logic [15:0]    healthy;
		logic [15:0]    conn;
	} report_t;

	// Status word as carried on m_tdata, tier in the lowest bits
	typedef struct packed {
		logic [6:0]        pad;
		logic [15:0]       min_conn;
		logic [15:0]       max_conn;
		logic [TIER_W-1:0] peak;
		logic [31:0]       starts;
		logic [31:0]       changes;
		logic [31:0]       coh_fails;
		logic [31:0]       health_fails;
		logic [31:0]       updates;
		logic              in_trans;
		logic [CAP_W-1:0]  cap;
		logic [TIER_W-1:0] tier;
	} status_word_t;

	typedef struct packed {
		logic         rejected;
		status_word_t word;
	} status_due_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [3:0]          paddr = '0;
	logic [31:0]         pwdata = '0;
	logic [31:0]         prdata;
	logic                pready;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [IN_BITS-1:0]  s_tdata = '0;   // connected_count, healthy_count, coherence_level
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OUT_BITS-1:0] m_tdata;        // tier, capability_mask, tier_pending,
	                                     // update_count, health_fail_count,
	                                     // coherence_fail_count, tier_change_count,
	                                     // violation_count, highest_tier,
	                                     // max_count_seen, min_count_seen
	logic                m_tuser;        // status

	group_tier_qualifier dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Bench copy of the configuration
	logic [Q_W-1:0]    thr_cfg;
	logic [STAB_W-1:0] stab_cfg;
	logic [Q_W-1:0]    ratio_cfg;

	// Bench copy of the tier state and statistics
	logic [TIER_W-1:0] tier_q, cand_q, peak_q;
	logic              pending_q;
	logic [7:0]        streak_q;
	logic [CAP_W-1:0]  cap_q;
	logic [31:0]       n_valid, n_health_fail, n_coh_fail, n_changes, n_starts;
	logic [15:0]       max_conn_q, min_conn_q;

	status_due_t status_due_q[$];
	int          err_count = 0;
	int          cycle_count = 0;
	int          burst_left = 0;
	int          stall_mode = 0;
	int          stall_phase = 0;
	int          stall_run = 0;
	logic        stall_level = 1'b1;

	task automatic report_mismatch(input string what);
		if (err_count < MAX_PRINT)
			$display("ERROR @%0t: %s", $time, what);
		err_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
		input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s: got %0h, expected %0h", name, got, want));
	endtask

	function automatic report_t rpt(input int conn, input int healthy, input int coh);
		report_t r;
		r.conn    = 16'(conn);
		r.healthy = 16'(healthy);
		r.coh     = Q_W'(coh);
		return r;
	endfunction

	// Model reset state
	task automatic clear_tier_model();
		thr_cfg       = gtq_pkg::COH_THR_RST;
		stab_cfg      = gtq_pkg::STAB_RST;
		ratio_cfg     = gtq_pkg::RATIO_RST;
		tier_q        = '0;
		cand_q        = '0;
		peak_q        = '0;
		pending_q     = 1'b0;
		streak_q      = '0;
		cap_q         = '0;
		n_valid       = '0;
		n_health_fail = '0;
		n_coh_fail    = '0;
		n_changes     = '0;
		n_starts      = '0;
		max_conn_q    = '0;
		min_conn_q    = '1;
	endtask

	function automatic logic [TIER_W-1:0] count_tier(input logic [15:0] c);
		if (c >= 32)      return 3'd5;
		else if (c >= 16) return 3'd4;
		else if (c >= 8)  return 3'd3;
		else if (c >= 4)  return 3'd2;
		else if (c >= 2)  return 3'd1;
		return 3'd0;
	endfunction

	// Smallest healthy count that passes the ratio check at this size
	function automatic longint healthy_floor(input logic [15:0] c);
		longint need;
		need = (longint'(ratio_cfg) * longint'(c) + 65535) >> 16;
		return need;
	endfunction

	// Apply one report to the model and return the status word it causes
	function automatic status_due_t predict_status(input report_t r);
		status_due_t       s;
		logic [TIER_W-1:0] raw;
		s = '0;
		if (r.healthy > r.conn || r.coh > gtq_pkg::Q_ONE) begin
			s.rejected = 1'b1;
		end else begin
			n_valid++;
			if (r.conn > max_conn_q) max_conn_q = r.conn;
			if (r.conn < min_conn_q) min_conn_q = r.conn;
			if (r.conn == 0 ||
				(longint'(r.healthy) << 16) < longint'(ratio_cfg) * longint'(r.conn)) begin
				n_health_fail++;
			end else if (r.coh < thr_cfg) begin
				n_coh_fail++;
			end else begin
				raw = count_tier(r.conn);
				if (raw == tier_q) begin
					streak_q  = '0;
					pending_q = 1'b0;
				end else if (!pending_q || raw != cand_q) begin
					cand_q    = raw;
					streak_q  = 8'd1;
					pending_q = 1'b1;
					n_starts++;
				end else begin
					streak_q = streak_q + 8'd1;
					if (streak_q >= stab_cfg) begin
						streak_q  = '0;
						pending_q = 1'b0;
						tier_q    = raw;
						n_changes++;
						if (raw > peak_q) peak_q = raw;
						cap_q = CAP_W'((11'd1 << (2 * raw)) - 11'd1);
					end
				end
			end
		end
		s.word.tier         = tier_q;
		s.word.cap          = cap_q;
		s.word.in_trans     = pending_q;
		s.word.updates      = n_valid;
		s.word.health_fails = n_health_fail;
		s.word.coh_fails    = n_coh_fail;
		s.word.changes      = n_changes;
		s.word.starts       = n_starts;
		s.word.peak         = peak_q;
		s.word.max_conn     = max_conn_q;
		s.word.min_conn     = min_conn_q;
		return s;
	endfunction

	// Send one request; bursts of random length with random gaps in between
	task automatic send_report(input report_t r);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			case ($urandom_range(0, 9))
				0, 1, 2, 3: gap = 0;
				9:          gap = $urandom_range(1, 30);
				default:    gap = $urandom_range(1, 6);
			endcase
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= {{(IN_BITS - $bits(report_t)){1'b0}}, r};
		do @(posedge clk); while (!s_tready);
		status_due_q.push_back(predict_status(r));
	endtask

	// Stop sending and let every status word come back
	task automatic drain();
		s_tvalid  <= 1'b0;
		burst_left = 0;
		while (status_due_q.size() != 0) @(posedge clk);
		repeat (TAIL_CYC) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input gtq_pkg::reg_idx_t idx,
		input logic [31:0] wdata, output logic [31:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Write one register with junk in the unused bits, then read it back
	task automatic write_reg(input gtq_pkg::reg_idx_t idx, input logic [31:0] value);
		logic [31:0] wdata;
		logic [31:0] want;
		logic [31:0] rdata;
		case (idx)
			gtq_pkg::REG_COH_THR: begin
				thr_cfg = value[Q_W-1:0];
				want    = 32'(thr_cfg);
				wdata   = {$urandom} << Q_W | want;
			end
			gtq_pkg::REG_STAB: begin
				stab_cfg = value[STAB_W-1:0];
				want     = 32'(stab_cfg);
				wdata    = {$urandom} << STAB_W | want;
			end
			default: begin
				ratio_cfg = value[Q_W-1:0];
				want      = 32'(ratio_cfg);
				wdata     = {$urandom} << Q_W | want;
			end
		endcase
		apb_access(1'b1, idx, wdata, rdata);
		apb_access(1'b0, idx, '0, rdata);
		check_field($sformatf("readback of register %s", idx.name()), rdata, want);
	endtask

	task automatic set_config(input int thr, input int stab, input int ratio);
		drain();
		write_reg(gtq_pkg::REG_COH_THR, 32'(thr));
		write_reg(gtq_pkg::REG_STAB, 32'(stab));
		write_reg(gtq_pkg::REG_RATIO, 32'(ratio));
	endtask

	// Report generators for the current configuration
	function automatic report_t qualifying_report(input int t);
		report_t r;
		longint  need;
		case (t)
			0:       r.conn = 16'd1;
			1:       r.conn = 16'($urandom_range(2, 3));
			2:       r.conn = 16'($urandom_range(4, 7));
			3:       r.conn = 16'($urandom_range(8, 15));
			4:       r.conn = 16'($urandom_range(16, 31));
			default: r.conn = $urandom_range(0, 1) ? 16'($urandom_range(32, 63))
				: 16'($urandom_range(32, 65535));
		endcase
		need = healthy_floor(r.conn);
		if (need > r.conn) need = r.conn;
		r.healthy = 16'($urandom_range(int'(need), int'(r.conn)));
		if (thr_cfg > gtq_pkg::Q_ONE) r.coh = Q_W'($urandom_range(0, 65536));
		else                          r.coh = Q_W'($urandom_range(int'(thr_cfg), 65536));
		return r;
	endfunction

	function automatic report_t broken_report();
		report_t r;
		longint  need;
		r = qualifying_report($urandom_range(0, 5));
		case ($urandom_range(0, 3))
			0: begin
				// health failure: empty group or too few healthy members
				need = healthy_floor(r.conn);
				if (need == 0 || $urandom_range(0, 3) == 0) begin
					r.conn    = '0;
					r.healthy = '0;
				end else begin
					r.healthy = 16'($urandom_range(0, int'(need) - 1));
				end
			end
			1: begin
				// coherence below threshold
				if (thr_cfg != 0)
					r.coh = Q_W'($urandom_range(0,
						(thr_cfg > gtq_pkg::Q_ONE ? 65536 : int'(thr_cfg) - 1)));
			end
			2: begin
				// more healthy than connected
				if (r.conn == 16'hFFFF) r.conn = 16'($urandom_range(0, 65534));
				r.healthy = 16'($urandom_range(int'(r.conn) + 1, 65535));
			end
			default: r.coh = Q_W'($urandom_range(65537, 131071));
		endcase
		return r;
	endfunction

	function automatic report_t noise_report();
		report_t r;
		r.conn    = 16'($urandom);
		r.healthy = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, int'(r.conn)));
		r.coh     = Q_W'($urandom);
		return r;
	endfunction

	// Mostly runs of one tier long enough to qualify, with breaks and noise
	task automatic run_random(input int n_items);
		int sent;
		int t;
		int len;
		int pick;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				t = $urandom_range(0, 5);
				if ($urandom_range(0, 2) == 0) len = $urandom_range(1, int'(stab_cfg) + 1);
				else                           len = int'(stab_cfg) + $urandom_range(0, 2);
				if (len < 1) len = 1;
				repeat (len) begin
					if ($urandom_range(0, 29) == 0) send_report(broken_report());
					else                            send_report(qualifying_report(t));
					sent++;
				end
			end else if (pick < 85) begin
				send_report(broken_report());
				sent++;
			end else begin
				send_report(noise_report());
				sent++;
			end
		end
	endtask

	// Field extremes, rejections, both checks and every tier decision
	task automatic test_directed_reports();
		send_report(rpt(0, 0, 0));              // empty group fails health
		send_report(rpt(65535, 65535, 65536));  // new candidate, top tier
		send_report(rpt(5, 6, 50000));          // healthy above connected
		send_report(rpt(5, 5, 65537));          // coherence above one
		send_report(rpt(65535, 0, 131071));     // all-ones coherence
		send_report(rpt(40, 40, 65536));        // same candidate
		send_report(rpt(2, 1, 50000));          // ratio exactly met, other candidate
		send_report(rpt(3, 1, 50000));          // ratio just missed
		send_report(rpt(100, 100, 45874));      // coherence just below threshold
		send_report(rpt(100, 100, 45875));      // threshold met, new candidate
		send_report(rpt(32, 32, 60000));
		send_report(rpt(32, 32, 60000));        // adopted on third reading
		send_report(rpt(1, 1, 65536));          // single member candidate
		send_report(rpt(1, 1, 65536));
		send_report(rpt(64, 64, 50000));        // back to adopted tier
		send_report(rpt(8, 8, 50000));
		send_report(rpt(8, 8, 50000));
		send_report(rpt(8, 8, 50000));          // step down adopted
		send_report(rpt(65535, 32768, 45875));
	endtask

	// Both edges of every tier, adopted on the second reading
	task automatic test_tier_bounds();
		int pairs [6][2] = '{'{1, 1}, '{2, 3}, '{4, 7}, '{8, 15}, '{16, 31}, '{32, 65535}};
		set_config(45875, 1, 32768);
		for (int i = 5; i >= 0; i--) begin
			send_report(rpt(pairs[i][0], pairs[i][0], 65536));
			send_report(rpt(pairs[i][1], pairs[i][1], 65536));
		end
	endtask

	task automatic test_default_settings();
		run_random(200);
	endtask

	task automatic test_low_extremes();
		set_config(0, 0, 0);
		run_random(200);
	endtask

	task automatic test_unity_settings();
		set_config(65536, 1, 65536);
		run_random(200);
	endtask

	task automatic test_threshold_out_of_range();
		set_config(131071, 2, 40000);
		run_random(100);
	endtask

	task automatic test_ratio_out_of_range();
		set_config(30000, 4, 131071);
		run_random(100);
	endtask

	task automatic test_long_qualification();
		set_config(20000, 255, 16384);
		run_random(300);
	endtask

	task automatic test_random_settings();
		repeat (2) begin
			set_config($urandom_range(0, 65536), $urandom_range(0, 12), $urandom_range(0, 65536));
			run_random(150);
		end
	endtask

	// Compare one status word with the oldest prediction
	task automatic check_status();
		status_due_t  want;
		status_word_t got;
		if (status_due_q.size() == 0) begin
			report_mismatch("status word with no report outstanding");
		end else begin
			want = status_due_q.pop_front();
			got  = m_tdata;
			check_field("status", 32'(m_tuser), 32'(want.rejected));
			check_field("tier", 32'(got.tier), 32'(want.word.tier));
			check_field("capability_mask", 32'(got.cap), 32'(want.word.cap));
			check_field("tier_pending", 32'(got.in_trans), 32'(want.word.in_trans));
			check_field("update_count", got.updates, want.word.updates);
			check_field("health_fail_count", got.health_fails, want.word.health_fails);
			check_field("coherence_fail_count", got.coh_fails, want.word.coh_fails);
			check_field("tier_change_count", got.changes, want.word.changes);
			check_field("violation_count", got.starts, want.word.starts);
			check_field("highest_tier", 32'(got.peak), 32'(want.word.peak));
			check_field("max_count_seen", 32'(got.max_conn), 32'(want.word.max_conn));
			check_field("min_count_seen", 32'(got.min_conn), 32'(want.word.min_conn));
		end
	endtask

	// Output side: check accepted words, stall on a changing pattern
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			check_status();
		if (stall_phase == 0) begin
			stall_mode  = $urandom_range(0, 3);
			stall_phase = $urandom_range(50, 300);
		end
		stall_phase--;
		case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			2: m_tready <= ($urandom_range(0, 9) != 0);
			default: begin
				if (stall_run == 0) begin
					stall_level = ~stall_level;
					stall_run   = $urandom_range(1, 15);
				end
				stall_run--;
				m_tready <= stall_level;
			end
		endcase
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= MAX_CYC) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		clear_tier_model();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_reports();
		test_default_settings();
		test_tier_bounds();
		test_low_extremes();
		test_unity_settings();
		test_threshold_out_of_range();
		test_ratio_out_of_range();
		test_long_qualification();
		test_random_settings();
		drain();
		if (err_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
